[src/stx_etx_frame_receiver_core_macros.svh]
// Assertion macros shared by the frame receiver checker.
`ifndef STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SEFR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SEFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sefr_pkg.sv]
// Package with the codes, constants and types of the STX/ETX frame receiver.
package sefr_pkg;

   localparam logic [7:0]  START_BYTE       = 8'h02;
   localparam logic [7:0]  END_BYTE         = 8'h03;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;
   localparam logic [1:0]  LAST_HEADER_IDX  = 2'd3;
   localparam logic [1:0]  LEN_HIGH_IDX     = 2'd2;

   // Result word kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // Frame verdicts.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_END  = 2'd1;
   localparam logic [1:0] STATUS_BAD_XOR  = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

   // Receive phases, one-hot.
   typedef enum logic [4:0] {
      PHASE_HUNT    = 5'b00001,
      PHASE_HEADER  = 5'b00010,
      PHASE_PAYLOAD = 5'b00100,
      PHASE_END     = 5'b01000,
      PHASE_CHECK   = 5'b10000
   } phase_type;

endpackage

[src/stx_etx_frame_receiver_core.sv]
// STX/ETX frame receiver core: start hunt, header, cut-through payload, XOR check verdict.
//
// Usage:
//   req_valid/req_ready/req_rx_byte carry received line bytes, one word per handshake.
//   rsp_valid/rsp_ready carry result words: rsp_data, rsp_kind (header, payload or
//   verdict), rsp_last and rsp_status (meaningful with rsp_last).
//   csr_wr_en/csr_wr_data write max_length; write only while the block is idle.
//   Bytes before a start byte, the start byte and the end byte give no result word.
//   The check byte gives the verdict word; a length above max_length ends the frame
//   at the fourth header byte with status too long.
// Path: a byte is captured in the input register at its accept edge, and its result word
//   is loaded into the output register when the byte advances.
// Throughput: one byte per cycle while no result stalls; the input and output registers
//   are the only stages, so a new byte is taken every cycle while results drain.
// Reset: synchronous, active high; hunting for a start byte, no result pending,
//   max_length set to 65535.
// Stall: while rsp_ready is low and a result word waits, the next byte that would give a
//   result holds in the input register and req_ready drops; bytes that give no result
//   still pass through.
module stx_etx_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff;
   logic [1:0]          rsp_kind_ff;
   logic                rsp_last_ff;
   logic [1:0]          rsp_status_ff;
   logic [15:0]         max_length_ff;
   sefr_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          header_count_ff, header_count_in;
   logic [7:0]          length_high_ff, length_high_in;
   logic [15:0]         remaining_ff, remaining_in;
   logic [7:0]          running_xor_ff, running_xor_in;
   logic                end_marker_ok_ff, end_marker_ok_in;
   logic                res_valid;
   logic [7:0]          res_data;
   logic [1:0]          res_kind;
   logic                res_last;
   logic [1:0]          res_status;
   logic [15:0]         frame_len;
   logic                advance;

   // The held byte moves on when it gives no word or the output register has room.
   assign advance   = in_valid_ff && (!res_valid || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign frame_len = {length_high_ff, in_byte_ff};

   // Frame parser: next state and result word for the held byte.
   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      length_high_in   = length_high_ff;
      remaining_in     = remaining_ff;
      running_xor_in   = running_xor_ff;
      end_marker_ok_in = end_marker_ok_ff;
      res_valid        = 1'b0;
      res_data         = in_byte_ff;
      res_kind         = sefr_pkg::KIND_HEADER;
      res_last         = 1'b0;
      res_status       = sefr_pkg::STATUS_OK;
      unique case (phase_ff)
         sefr_pkg::PHASE_HEADER: begin
            running_xor_in = running_xor_ff ^ in_byte_ff;
            res_valid      = 1'b1;
            if (header_count_ff == sefr_pkg::LEN_HIGH_IDX) begin
               length_high_in = in_byte_ff;
            end
            if (header_count_ff != sefr_pkg::LAST_HEADER_IDX) begin
               header_count_in = header_count_ff + 2'd1;
            end else begin
               header_count_in = 2'd0;
               if (frame_len > max_length_ff) begin
                  phase_in   = sefr_pkg::PHASE_HUNT;
                  res_last   = 1'b1;
                  res_status = sefr_pkg::STATUS_TOO_LONG;
               end else begin
                  remaining_in = frame_len;
                  phase_in     = (frame_len == 16'd0) ? sefr_pkg::PHASE_END
                                                      : sefr_pkg::PHASE_PAYLOAD;
               end
            end
         end
         sefr_pkg::PHASE_PAYLOAD: begin
            running_xor_in = running_xor_ff ^ in_byte_ff;
            remaining_in   = remaining_ff - 16'd1;
            res_valid      = 1'b1;
            res_kind       = sefr_pkg::KIND_PAYLOAD;
            if (remaining_in == 16'd0) begin
               phase_in = sefr_pkg::PHASE_END;
            end
         end
         sefr_pkg::PHASE_END: begin
            end_marker_ok_in = (in_byte_ff == sefr_pkg::END_BYTE);
            phase_in         = sefr_pkg::PHASE_CHECK;
         end
         sefr_pkg::PHASE_CHECK: begin
            res_valid = 1'b1;
            res_kind  = sefr_pkg::KIND_VERDICT;
            res_last  = 1'b1;
            phase_in  = sefr_pkg::PHASE_HUNT;
            if (!end_marker_ok_ff) begin
               res_status = sefr_pkg::STATUS_BAD_END;
            end else if (in_byte_ff != running_xor_ff) begin
               res_status = sefr_pkg::STATUS_BAD_XOR;
            end
         end
         default: begin
            // Hunting: only a start byte opens a frame.
            if (in_byte_ff == sefr_pkg::START_BYTE) begin
               phase_in         = sefr_pkg::PHASE_HEADER;
               header_count_in  = 2'd0;
               length_high_in   = 8'd0;
               remaining_in     = 16'd0;
               running_xor_in   = 8'd0;
               end_marker_ok_in = 1'b0;
            end else begin
               phase_in = sefr_pkg::PHASE_HUNT;
            end
         end
      endcase
   end

   // Output register loads a new word or empties when the word is taken.
   always_comb begin
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         max_length_ff    <= sefr_pkg::MAX_LENGTH_RESET;
         phase_ff         <= sefr_pkg::PHASE_HUNT;
         header_count_ff  <= 2'd0;
         length_high_ff   <= 8'd0;
         remaining_ff     <= 16'd0;
         running_xor_ff   <= 8'd0;
         end_marker_ok_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_valid || (in_valid_ff && !advance);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_length_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff         <= phase_in;
            header_count_ff  <= header_count_in;
            length_high_ff   <= length_high_in;
            remaining_ff     <= remaining_in;
            running_xor_ff   <= running_xor_in;
            end_marker_ok_ff <= end_marker_ok_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && res_valid) begin
         rsp_data_ff   <= res_data;
         rsp_kind_ff   <= res_kind;
         rsp_last_ff   <= res_last;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[src/sefr_checker.sv]
// Port checker for the frame receiver core and its bind statement.
`include "stx_etx_frame_receiver_core_macros.svh"

module sefr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data,
   input logic [1:0]  rsp_kind,
   input logic        rsp_last,
   input logic [1:0]  rsp_status
);

   // A stalled result word holds.
   `SEFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_kind) && $stable(rsp_last) && $stable(rsp_status), "result word changed while stalled")

   // A frame ends either on its verdict or on a header cut for length.
   `SEFR_ASSERT_IMPLY(a_last_kind, clock, reset, rsp_valid && rsp_last, rsp_kind == sefr_pkg::KIND_VERDICT || (rsp_kind == sefr_pkg::KIND_HEADER && rsp_status == sefr_pkg::STATUS_TOO_LONG), "frame end on wrong kind")

   // Words inside a frame carry no verdict.
   `SEFR_ASSERT_IMPLY(a_mid_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == sefr_pkg::STATUS_OK && rsp_kind != sefr_pkg::KIND_VERDICT, "verdict inside a frame")

   // A verdict word is always the last of its frame and never too long.
   `SEFR_ASSERT_IMPLY(a_verdict_last, clock, reset, rsp_valid && rsp_kind == sefr_pkg::KIND_VERDICT, rsp_last && rsp_status != sefr_pkg::STATUS_TOO_LONG, "bad verdict word")

   // No result word right after reset.
   `SEFR_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind stx_etx_frame_receiver_core sefr_checker u_sefr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .rsp_kind   (rsp_kind),
   .rsp_last   (rsp_last),
   .rsp_status (rsp_status)
);
